/* hw/rtl/nearest_reference_line_associator_macros.svh */
// assertion helpers for the nearest reference line associator
`ifndef NEAREST_REFERENCE_LINE_ASSOCIATOR_MACROS_SVH
`define NEAREST_REFERENCE_LINE_ASSOCIATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NRLA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NRLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/nrla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nrla_pkg;

	localparam int NUM_POINTS = 64;
	localparam int MAX_OBJ    = 4;

	localparam int VAL_W      = 16;
	localparam int DIR_W      = 13;
	localparam int ONE_Q12    = 4096;
	localparam int DIST_LIMIT = 2;

	localparam int OBJ_IDX_W = $clog2(MAX_OBJ);
	localparam int OBJ_CNT_W = $clog2(MAX_OBJ + 1);
	localparam int PT_IDX_W  = $clog2(NUM_POINTS);
	localparam int PT_CNT_W  = $clog2(NUM_POINTS + 1);
	localparam int OUT_IDX_W = 6;
	localparam int CFG_W     = 7;

	localparam int MAG_W    = 16;
	localparam int A2_W     = 33;
	localparam int P2_W     = 27;
	localparam int D_W      = 31;
	localparam int DABS_W   = 30;
	localparam int N_W      = 59;
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = 30;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int Q_W      = 26;
	localparam int BEST_W   = Q_W + 1;
	localparam int DIV_CNT_W = $clog2(Q_W);

	localparam logic [BEST_W-1:0] BEST_INIT = BEST_W'((DIST_LIMIT * DIST_LIMIT) << 24);

	localparam logic [OBJ_CNT_W-1:0] OBJ_MIN   = OBJ_CNT_W'(2);
	localparam logic [OBJ_CNT_W-1:0] OBJ_MAX   = OBJ_CNT_W'(MAX_OBJ);
	localparam logic [OBJ_CNT_W-1:0] OBJ_RESET = OBJ_CNT_W'(3);
	localparam logic [PT_CNT_W-1:0]  CNT_MAX   = PT_CNT_W'(NUM_POINTS);
	localparam logic [PT_CNT_W-1:0]  CNT_RESET = '0;

	typedef enum logic [0:0] {
		REG_OBJECTIVES  = 1'b0,
		REG_POINT_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	// what to do with the product when it leaves the multiplier register
	typedef enum logic [2:0] {
		OP_NONE,
		OP_A2,
		OP_P2,
		OP_DOT,
		OP_SETN,
		OP_SUBN
	} mul_op_t;

	typedef logic [MAX_OBJ-1:0][DIR_W-1:0] dir_row_t;

	function automatic logic [DIR_W-1:0] clamp_dir(input logic signed [VAL_W-1:0] v);
		logic [DIR_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > ONE_Q12) begin
			r = DIR_W'(ONE_Q12);
		end else begin
			r = v[DIR_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/nearest_reference_line_associator.sv */
// a load is written at acceptance and gives no result
// a query squares its n objectives in use, then per direction reads the row, forms p2, the dot product
// and the numerator, skips a zero-length one, and runs the divider only when it improves the best
// throughput: one item at a time; a result still stalled at the output holds the next one back
// reset (arst_n low, asynchronous): idle, objectives_in_use = 3, point_count = 0, no result pending
// the direction table is not cleared by reset
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_reference_line_associator_macros.svh"

module nearest_reference_line_associator (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [0:0]                             cfg_index,
	input  wire logic [nrla_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   mode,
	input  wire logic [nrla_pkg::PT_IDX_W-1:0]          point_index,
	input  wire logic signed [nrla_pkg::VAL_W-1:0]      value_0,
	input  wire logic signed [nrla_pkg::VAL_W-1:0]      value_1,
	input  wire logic signed [nrla_pkg::VAL_W-1:0]      value_2,
	input  wire logic signed [nrla_pkg::VAL_W-1:0]      value_3,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [nrla_pkg::OUT_IDX_W-1:0]              nearest_index,
	output logic                                        found
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQ_A,
		S_RD,
		S_PP,
		S_AP,
		S_NUM1,
		S_NUM2,
		S_CMP,
		S_CHK,
		S_DIV,
		S_NEXT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [nrla_pkg::OBJ_CNT_W-1:0] objectives_in_use_q;
	logic [nrla_pkg::PT_CNT_W-1:0]  point_count_q;

	logic [nrla_pkg::OBJ_CNT_W-1:0] nobj_q;
	logic [nrla_pkg::PT_CNT_W-1:0]  cnt_q;
	logic [nrla_pkg::OBJ_IDX_W-1:0] k_q;
	logic [nrla_pkg::PT_CNT_W-1:0]  j_q;
	logic [nrla_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                           hit_q;
	logic [nrla_pkg::PT_IDX_W-1:0]  best_idx_q;
	logic                           out_valid_q;
	logic [nrla_pkg::OUT_IDX_W-1:0] nearest_index_q;
	logic                           found_q;

	nrla_pkg::mul_op_t               op_s1;
	logic                            neg_s1;
	logic [nrla_pkg::PROD_W-1:0]     prod_s1;

	logic signed [nrla_pkg::VAL_W-1:0] in_vals [nrla_pkg::MAX_OBJ];
	logic [nrla_pkg::MAG_W-1:0]        a_mag_q [nrla_pkg::MAX_OBJ];
	logic [nrla_pkg::MAX_OBJ-1:0]      a_neg_q;
	logic [nrla_pkg::A2_W-1:0]         a2_q;
	logic [nrla_pkg::P2_W-1:0]         p2_q;
	logic signed [nrla_pkg::D_W-1:0]   d_q;
	logic [nrla_pkg::N_W-1:0]          n_q;
	logic [nrla_pkg::BEST_W-1:0]       best_q;
	logic [nrla_pkg::N_W-1:0]          rem_q;
	logic [nrla_pkg::N_W-1:0]          dv_q;
	logic [nrla_pkg::Q_W-1:0]          quo_q;

	nrla_pkg::dir_row_t dir_mem [nrla_pkg::NUM_POINTS];
	nrla_pkg::dir_row_t rd_row_q;
	nrla_pkg::dir_row_t ld_row;

	logic                             in_accept;
	logic                             load_accept;
	logic                             query_accept;
	logic                             last_k;
	logic                             last_j;
	logic                             div_last;
	logic                             cand;
	logic [nrla_pkg::DIR_W-1:0]       p_cur;
	logic [nrla_pkg::DABS_W-1:0]      dabs;
	logic [nrla_pkg::MUL_A_W-1:0]     mul_a;
	logic [nrla_pkg::MUL_B_W-1:0]     mul_b;
	nrla_pkg::mul_op_t                mul_op;
	logic                             mul_neg;
	logic signed [nrla_pkg::D_W-1:0]  dot_term;
	logic                             div_take;
	logic [nrla_pkg::N_W-1:0]         rem_nxt;
	logic [nrla_pkg::Q_W-1:0]         quo_nxt;

	assign in_vals[0] = value_0;
	assign in_vals[1] = value_1;
	assign in_vals[2] = value_2;
	assign in_vals[3] = value_3;

	assign in_stall     = (state_q != S_IDLE);
	assign in_accept    = in_valid && !in_stall;
	assign load_accept  = in_accept && (mode == nrla_pkg::MODE_LOAD);
	assign query_accept = in_accept && (mode == nrla_pkg::MODE_QUERY);

	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_index_q;
	assign found         = found_q;

	assign last_k   = (nrla_pkg::OBJ_CNT_W'(k_q) == nobj_q - nrla_pkg::OBJ_CNT_W'(1));
	assign last_j   = (j_q == cnt_q - nrla_pkg::PT_CNT_W'(1));
	assign div_last = (div_cnt_q == nrla_pkg::DIV_CNT_W'(nrla_pkg::Q_W - 1));
	assign p_cur    = rd_row_q[k_q];
	assign dabs     = d_q[nrla_pkg::D_W-1] ? nrla_pkg::DABS_W'(-d_q) : nrla_pkg::DABS_W'(d_q);
	// candidate only if floor(n / p2) < best, i.e. n < best * p2
	assign cand     = (nrla_pkg::PROD_W'(n_q) < prod_s1);

	always_comb begin
		for (int i = 0; i < nrla_pkg::MAX_OBJ; i++) begin
			ld_row[i] = nrla_pkg::clamp_dir(in_vals[i]);
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_op  = nrla_pkg::OP_NONE;
		mul_neg = 1'b0;
		unique case (state_q)
			S_SQ_A: begin
				mul_a  = nrla_pkg::MUL_A_W'(a_mag_q[k_q]);
				mul_b  = nrla_pkg::MUL_B_W'(a_mag_q[k_q]);
				mul_op = nrla_pkg::OP_A2;
			end
			S_PP: begin
				mul_a  = nrla_pkg::MUL_A_W'(p_cur);
				mul_b  = nrla_pkg::MUL_B_W'(p_cur);
				mul_op = nrla_pkg::OP_P2;
			end
			S_AP: begin
				mul_a   = nrla_pkg::MUL_A_W'(a_mag_q[k_q]);
				mul_b   = nrla_pkg::MUL_B_W'(p_cur);
				mul_op  = nrla_pkg::OP_DOT;
				mul_neg = a_neg_q[k_q];
			end
			S_NUM1: begin
				mul_a  = a2_q;
				mul_b  = nrla_pkg::MUL_B_W'(p2_q);
				mul_op = (p2_q != '0) ? nrla_pkg::OP_SETN : nrla_pkg::OP_NONE;
			end
			S_NUM2: begin
				mul_a  = nrla_pkg::MUL_A_W'(dabs);
				mul_b  = dabs;
				mul_op = nrla_pkg::OP_SUBN;
			end
			S_CMP: begin
				mul_a = nrla_pkg::MUL_A_W'(best_q);
				mul_b = nrla_pkg::MUL_B_W'(p2_q);
			end
			default: begin
			end
		endcase
	end

	assign dot_term = $signed(nrla_pkg::D_W'(prod_s1));
	assign div_take = (rem_q >= dv_q);
	assign rem_nxt  = div_take ? (rem_q - dv_q) : rem_q;
	assign quo_nxt  = {quo_q[nrla_pkg::Q_W-2:0], div_take};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			objectives_in_use_q <= nrla_pkg::OBJ_RESET;
			point_count_q       <= nrla_pkg::CNT_RESET;
		end else if (cfg_we) begin
			unique case (nrla_pkg::cfg_reg_t'(cfg_index))
				nrla_pkg::REG_OBJECTIVES:  objectives_in_use_q <= cfg_data[nrla_pkg::OBJ_CNT_W-1:0];
				nrla_pkg::REG_POINT_COUNT: point_count_q       <= cfg_data[nrla_pkg::PT_CNT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_accept && (nrla_pkg::PT_CNT_W'(point_index) < nrla_pkg::CNT_MAX)) begin
			dir_mem[point_index] <= ld_row;
		end
		if (state_q == S_RD) begin
			rd_row_q <= dir_mem[j_q[nrla_pkg::PT_IDX_W-1:0]];
		end
	end

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			nobj_q          <= nrla_pkg::OBJ_RESET;
			cnt_q           <= '0;
			k_q             <= '0;
			j_q             <= '0;
			div_cnt_q       <= '0;
			hit_q           <= 1'b0;
			best_idx_q      <= '0;
			op_s1           <= nrla_pkg::OP_NONE;
			neg_s1          <= 1'b0;
			out_valid_q     <= 1'b0;
			nearest_index_q <= '0;
			found_q         <= 1'b0;
		end else begin
			op_s1  <= mul_op;
			neg_s1 <= mul_neg;
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (query_accept) begin
						if (objectives_in_use_q < nrla_pkg::OBJ_MIN) begin
							nobj_q <= nrla_pkg::OBJ_MIN;
						end else if (objectives_in_use_q > nrla_pkg::OBJ_MAX) begin
							nobj_q <= nrla_pkg::OBJ_MAX;
						end else begin
							nobj_q <= objectives_in_use_q;
						end
						cnt_q      <= (point_count_q > nrla_pkg::CNT_MAX) ?
							nrla_pkg::CNT_MAX : point_count_q;
						hit_q      <= 1'b0;
						best_idx_q <= '0;
						k_q        <= '0;
						state_q    <= S_SQ_A;
					end
				end
				S_SQ_A: begin
					if (last_k) begin
						k_q <= '0;
						j_q <= '0;
						state_q <= (cnt_q == '0) ? S_DONE : S_RD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_RD: begin
					k_q     <= '0;
					state_q <= S_PP;
				end
				S_PP: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= S_AP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_AP: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= S_NUM1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_NUM1: begin
					// zero-length direction is skipped
					state_q <= (p2_q == '0) ? S_NEXT : S_NUM2;
				end
				S_NUM2: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					div_cnt_q <= '0;
					state_q   <= cand ? S_DIV : S_NEXT;
				end
				S_DIV: begin
					if (div_last) begin
						hit_q      <= 1'b1;
						best_idx_q <= j_q[nrla_pkg::PT_IDX_W-1:0];
						state_q    <= S_NEXT;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				S_NEXT: begin
					if (last_j) begin
						state_q <= S_DONE;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						nearest_index_q <= hit_q ? nrla_pkg::OUT_IDX_W'(best_idx_q) : '0;
						found_q         <= hit_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: multiplier register, accumulators and the restoring divider
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;

		unique case (op_s1)
			nrla_pkg::OP_A2:   a2_q <= a2_q + nrla_pkg::A2_W'(prod_s1);
			nrla_pkg::OP_P2:   p2_q <= p2_q + nrla_pkg::P2_W'(prod_s1);
			nrla_pkg::OP_DOT:  d_q  <= neg_s1 ? (d_q - dot_term) : (d_q + dot_term);
			nrla_pkg::OP_SETN: n_q  <= nrla_pkg::N_W'(prod_s1);
			nrla_pkg::OP_SUBN: n_q  <= n_q - nrla_pkg::N_W'(prod_s1);
			default: begin
			end
		endcase

		if (query_accept) begin
			for (int i = 0; i < nrla_pkg::MAX_OBJ; i++) begin
				a_mag_q[i] <= in_vals[i][nrla_pkg::VAL_W-1] ?
					nrla_pkg::MAG_W'(-in_vals[i]) : nrla_pkg::MAG_W'(in_vals[i]);
				a_neg_q[i] <= in_vals[i][nrla_pkg::VAL_W-1];
			end
			a2_q   <= '0;
			best_q <= nrla_pkg::BEST_INIT;
		end

		if (state_q == S_RD) begin
			p2_q <= '0;
			d_q  <= '0;
		end

		if (state_q == S_CHK) begin
			rem_q <= n_q;
			dv_q  <= nrla_pkg::N_W'(p2_q) << (nrla_pkg::Q_W - 1);
			quo_q <= '0;
		end

		if (state_q == S_DIV) begin
			rem_q <= rem_nxt;
			dv_q  <= dv_q >> 1;
			quo_q <= quo_nxt;
			if (div_last) begin
				best_q <= nrla_pkg::BEST_W'(quo_nxt);
			end
		end
	end

	`NRLA_ASSERT_IMPL(a_no_hit_zero_index, clk, arst_n, out_valid && !found, nearest_index == '0, "result without a hit carries a nonzero index")
	`NRLA_ASSERT_NEXT(a_query_starts, clk, arst_n, query_accept, state_q == S_SQ_A, "accepted query did not start the search")
	`NRLA_ASSERT_NEXT(a_div_improves, clk, arst_n, (state_q == S_DIV) && div_last, best_q < $past(best_q), "divider result does not improve the best distance")
	`NRLA_ASSERT_NEXT(a_div_remainder, clk, arst_n, (state_q == S_DIV) && div_last, rem_q < nrla_pkg::N_W'(p2_q), "divider remainder not below the divisor")
	`NRLA_ASSERT_IMPL(a_hit_below_limit, clk, arst_n, (state_q != S_IDLE) && hit_q, best_q < nrla_pkg::BEST_INIT, "hit recorded with distance at or above the limit")

endmodule

`default_nettype wire

/* test/line_association_checker.sv */
`timescale 1ns / 1ps

module line_association_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [nrla_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               mode,
	input  logic [nrla_pkg::PT_IDX_W-1:0]      point_index,
	input  logic signed [nrla_pkg::VAL_W-1:0]  value_0,
	input  logic signed [nrla_pkg::VAL_W-1:0]  value_1,
	input  logic signed [nrla_pkg::VAL_W-1:0]  value_2,
	input  logic signed [nrla_pkg::VAL_W-1:0]  value_3,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [nrla_pkg::OUT_IDX_W-1:0]     nearest_index,
	input  logic                               found,
	output int                                 fail_count,
	output int                                 pending_count,
	output int                                 load_total,
	output int                                 query_total,
	output int                                 hit_total
);

	import nrla_pkg::*;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		logic                 hit;
	} association_t;

	logic [DIR_W-1:0]     dir_store [NUM_POINTS][MAX_OBJ];
	logic [OBJ_CNT_W-1:0] objectives_reg;
	logic [PT_CNT_W-1:0]  count_reg;
	association_t         expected_q [$];
	association_t         want;
	logic [MAX_OBJ-1:0][VAL_W-1:0] request_values;

	// negative components go to zero, anything past 1.0 is held at 1.0
	function automatic logic [DIR_W-1:0] saturate_dir(input logic signed [VAL_W-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > ONE_Q12) begin
			return DIR_W'(ONE_Q12);
		end
		return v[DIR_W-1:0];
	endfunction

	// closest reference line by squared perpendicular distance, for a distance below 2.0 only
	function automatic association_t associate(input logic [MAX_OBJ-1:0][VAL_W-1:0] obj);
		int              nobj;
		int              cnt;
		longint signed   av [MAX_OBJ];
		longint signed   d;
		longint signed   pv;
		longint unsigned a2;
		longint unsigned p2;
		longint unsigned dabs;
		longint unsigned q;
		longint unsigned best;
		association_t    r;
		nobj = objectives_reg;
		if (nobj < 2) nobj = 2;
		if (nobj > MAX_OBJ) nobj = MAX_OBJ;
		cnt = count_reg;
		if (cnt > NUM_POINTS) cnt = NUM_POINTS;
		a2 = 0;
		for (int k = 0; k < nobj; k++) begin
			av[k] = longint'($signed(obj[k]));
			a2 += av[k] * av[k];
		end
		best = longint'(DIST_LIMIT * DIST_LIMIT) << 24;
		r = '0;
		for (int j = 0; j < cnt; j++) begin
			p2 = 0;
			d = 0;
			for (int k = 0; k < nobj; k++) begin
				pv = longint'(dir_store[j][k]);
				p2 += pv * pv;
				d += av[k] * pv;
			end
			if (p2 != 0) begin
				dabs = (d < 0) ? -d : d;
				q = (a2 * p2 - dabs * dabs) / p2;
				// strict compare keeps the earliest of equal distances
				if (q < best) begin
					best = q;
					r.index = OUT_IDX_W'(j);
					r.hit = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			objectives_reg = OBJ_RESET;
			count_reg = CNT_RESET;
			expected_q.delete();
			pending_count = 0;
			fail_count = 0;
			load_total = 0;
			query_total = 0;
			hit_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with no query waiting, expected none, actual index %0d found %0d",
						$time, nearest_index, found);
				end else begin
					want = expected_q.pop_front();
					if (nearest_index !== want.index) begin
						fail_count++;
						$display("%0t: nearest_index mismatch, expected %0d, actual %0d",
							$time, want.index, nearest_index);
					end
					if (found !== want.hit) begin
						fail_count++;
						$display("%0t: found mismatch, expected %0d, actual %0d",
							$time, want.hit, found);
					end
					if (found === 1'b1) hit_total++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_OBJECTIVES) begin
					objectives_reg = cfg_data[OBJ_CNT_W-1:0];
				end else begin
					count_reg = cfg_data[PT_CNT_W-1:0];
				end
			end
			if (in_valid && !in_stall) begin
				request_values = {value_3, value_2, value_1, value_0};
				if (mode == MODE_LOAD) begin
					for (int k = 0; k < MAX_OBJ; k++) begin
						dir_store[point_index][k] = saturate_dir(request_values[k]);
					end
					load_total++;
				end else begin
					expected_q = {expected_q, associate(request_values)};
					query_total++;
				end
			end
			pending_count = expected_q.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	import nrla_pkg::*;

	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_style_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [0:0]                    cfg_index;
	logic [CFG_W-1:0]              cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          mode;
	logic [PT_IDX_W-1:0]           point_index;
	logic signed [VAL_W-1:0]       value_0;
	logic signed [VAL_W-1:0]       value_1;
	logic signed [VAL_W-1:0]       value_2;
	logic signed [VAL_W-1:0]       value_3;
	logic                          out_valid;
	logic                          out_stall;
	logic [OUT_IDX_W-1:0]          nearest_index;
	logic                          found;

	int fail_count;
	int pending_count;
	int load_total;
	int query_total;
	int hit_total;

	int sender_idle_pct;
	int stall_pct;
	int eff_count;
	int setting_total;
	// clamped copy of what was loaded, used to aim queries near a line
	int row_dir [NUM_POINTS][MAX_OBJ];

	nearest_reference_line_associator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.point_index   (point_index),
		.value_0       (value_0),
		.value_1       (value_1),
		.value_2       (value_2),
		.value_3       (value_3),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.found         (found)
	);

	line_association_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.point_index   (point_index),
		.value_0       (value_0),
		.value_1       (value_1),
		.value_2       (value_2),
		.value_3       (value_3),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.found         (found),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.load_total    (load_total),
		.query_total   (query_total),
		.hit_total     (hit_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("timeout with %0d results outstanding", pending_count);
		$display("*** FAILED ***");
		$finish;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// present one request after a random gap and hold it until accepted
	task automatic offer(input logic m, input logic [PT_IDX_W-1:0] idx,
			input logic [MAX_OBJ-1:0][VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		point_index = idx;
		value_0 = v[0];
		value_1 = v[1];
		value_2 = v[2];
		value_3 = v[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait for every outstanding result, then a few quiet cycles
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(input int obj, input int cnt);
		logic [CFG_W-1:0] d;
		settle();
		d = CFG_W'(obj & 7);
		// upper data bits are outside the register and must be dropped
		if ($urandom_range(1) == 1) d = d | CFG_W'($urandom_range(15) << 3);
		write_reg(REG_OBJECTIVES, d);
		write_reg(REG_POINT_COUNT, CFG_W'(cnt));
		eff_count = (cnt > NUM_POINTS) ? NUM_POINTS : cnt;
		setting_total++;
	endtask

	task automatic load4(input int idx, input int c0, input int c1, input int c2, input int c3);
		logic [MAX_OBJ-1:0][VAL_W-1:0] v;
		int raw;
		v = {VAL_W'(c3), VAL_W'(c2), VAL_W'(c1), VAL_W'(c0)};
		for (int k = 0; k < MAX_OBJ; k++) begin
			raw = int'($signed(v[k]));
			row_dir[idx][k] = (raw < 0) ? 0 : (raw > ONE_Q12) ? ONE_Q12 : raw;
		end
		offer(MODE_LOAD, PT_IDX_W'(idx), v);
	endtask

	task automatic query4(input int c0, input int c1, input int c2, input int c3);
		offer(MODE_QUERY, PT_IDX_W'($urandom_range(NUM_POINTS - 1)),
			{VAL_W'(c3), VAL_W'(c2), VAL_W'(c1), VAL_W'(c0)});
	endtask

	task automatic random_item();
		int c [MAX_OBJ];
		int pick;
		int sel;
		int src;
		int t;
		int noise;
		int j;
		pick = $urandom_range(99);
		if (pick < 40) begin
			sel = $urandom_range(9);
			src = $urandom_range(NUM_POINTS - 1);
			for (int k = 0; k < MAX_OBJ; k++) begin
				if (sel == 0) begin
					c[k] = 0;
				end else if (sel == 1) begin
					// duplicate line, so equal distances occur
					c[k] = row_dir[src][k];
				end else begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5, 6: c[k] = $urandom_range(ONE_Q12);
						7, 8: c[k] = int'($signed(VAL_W'($urandom)));
						default: c[k] = ONE_Q12 + $urandom_range(1);
					endcase
				end
			end
			load4($urandom_range(NUM_POINTS - 1), c[0], c[1], c[2], c[3]);
		end else begin
			sel = $urandom_range(99);
			j = (eff_count > 0) ? $urandom_range(eff_count - 1) : 0;
			t = $urandom_range(2 * ONE_Q12);
			for (int k = 0; k < MAX_OBJ; k++) begin
				if (sel < 50) begin
					// a point near line j, scaled by up to 2.0
					if (sel < 10) begin
						noise = $urandom_range(16383);
						noise = noise - 8192;
					end else begin
						noise = $urandom_range(4095);
						noise = noise - 2048;
					end
					c[k] = ((row_dir[j][k] * t) >>> 12) + noise;
				end else if (sel < 75) begin
					c[k] = $urandom_range(16383);
					c[k] = c[k] - 8192;
				end else if (sel < 97) begin
					c[k] = int'($signed(VAL_W'($urandom)));
				end else begin
					c[k] = 0;
				end
			end
			query4(c[0], c[1], c[2], c[3]);
		end
		if ($urandom_range(49) == 0) settle();
	endtask

	task automatic run_phase(input int obj, input int cnt, input int items,
			input idle_style_t style);
		configure(obj, cnt);
		@(posedge clk);
		case (style)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 52;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				stall_pct = 52;
			end
			default: begin
				sender_idle_pct = 26;
				stall_pct = 26;
			end
		endcase
		repeat (items) random_item();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OBJECTIVES;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		point_index = '0;
		value_0 = '0;
		value_1 = '0;
		value_2 = '0;
		value_3 = '0;
		out_stall = 1'b0;
		sender_idle_pct = 0;
		stall_pct = 0;
		eff_count = 0;
		setting_total = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// every entry is written before any query can reach it
		for (int i = 0; i < NUM_POINTS; i++) begin
			if ($urandom_range(15) == 0) begin
				load4(i, 0, 0, 0, 0);
			end else begin
				load4(i, $urandom_range(ONE_Q12), $urandom_range(ONE_Q12),
					$urandom_range(ONE_Q12), $urandom_range(ONE_Q12));
			end
		end

		// saturation at both ends, zero length, duplicate lines
		load4(0, -32768, 32767, ONE_Q12, ONE_Q12 + 1);
		load4(1, 0, 0, 0, 0);
		load4(2, ONE_Q12, 0, 0, 0);
		load4(3, ONE_Q12, 0, 0, 0);
		load4(4, 0, ONE_Q12, 0, 0);
		load4(5, -1, 1, ONE_Q12 - 1, 0);
		load4(6, 0, 0, 0, ONE_Q12);
		load4(7, 2048, 2048, 2048, 2048);
		configure(4, 8);
		query4(0, 0, 0, 0);
		query4(2 * ONE_Q12, 0, 0, 0);
		query4(32767, 32767, 32767, 32767);
		query4(-32768, -32768, -32768, -32768);
		query4(-32768, 32767, -32768, 32767);
		query4(0, 0, 0, 3 * ONE_Q12);
		query4(8191, 0, 0, 8191);
		query4(0, 8191, 8190, 0);
		query4(4096, 4096, 4096, 4096);
		query4(-8192, 0, 0, 0);
		configure(2, 8);
		query4(0, 0, 32767, -32768);
		query4(ONE_Q12, ONE_Q12, -32768, 32767);
		query4(-ONE_Q12, 3 * ONE_Q12, 0, 0);

		run_phase(2, 5, 120, IDLE_NONE);
		run_phase(3, 12, 120, IDLE_SENDER);
		run_phase(4, 8, 120, IDLE_RECEIVER);
		run_phase(0, 0, 60, IDLE_BOTH);
		run_phase(7, 3, 120, IDLE_NONE);
		run_phase(1, 1, 100, IDLE_SENDER);
		run_phase(4, 64, 30, IDLE_RECEIVER);
		run_phase(5, 127, 20, IDLE_BOTH);
		run_phase(2, 64, 30, IDLE_NONE);
		run_phase(3, 16, 150, IDLE_SENDER);
		run_phase(4, 2, 150, IDLE_RECEIVER);
		run_phase(6, 65, 20, IDLE_BOTH);
		run_phase(3, 10, 130, IDLE_NONE);

		settle();
		repeat (50) @(negedge clk);
		$display("run covered %0d direction loads and %0d queries over %0d register settings",
			load_total, query_total, setting_total);
		$display("%0d queries found a line within range, %0d mismatches",
			hit_total, fail_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
